// File: src/fjot_pkg.sv
package fjot_pkg;

    localparam int WS_DEPTH = 16;
    localparam int WS_AW = $clog2(WS_DEPTH);
    localparam int WS_CW = $clog2(WS_DEPTH + 1);

    localparam logic [2:0] KIND_KEY_BYTE = 3'd0;
    localparam logic [2:0] KIND_VAL_BYTE = 3'd1;
    localparam logic [2:0] KIND_KEY_END  = 3'd2;
    localparam logic [2:0] KIND_PAIR_END = 3'd3;
    localparam logic [2:0] KIND_STATUS   = 3'd4;

    localparam logic [4:0] ERR_NONE        = 5'd0;
    localparam logic [4:0] ERR_EXP_STRING  = 5'd1;
    localparam logic [4:0] ERR_UNT_ESCAPE  = 5'd2;
    localparam logic [4:0] ERR_BAD_UNICODE = 5'd3;
    localparam logic [4:0] ERR_HIGH_NO_U   = 5'd4;
    localparam logic [4:0] ERR_BAD_LOW     = 5'd5;
    localparam logic [4:0] ERR_LONE_LOW    = 5'd6;
    localparam logic [4:0] ERR_BAD_ESCAPE  = 5'd7;
    localparam logic [4:0] ERR_UNT_STRING  = 5'd8;
    localparam logic [4:0] ERR_NO_VALUE    = 5'd9;
    localparam logic [4:0] ERR_NESTED      = 5'd10;
    localparam logic [4:0] ERR_NO_SCALAR   = 5'd11;
    localparam logic [4:0] ERR_EXP_OBJECT  = 5'd12;
    localparam logic [4:0] ERR_EXP_COLON   = 5'd13;
    localparam logic [4:0] ERR_UNT_OBJECT  = 5'd14;
    localparam logic [4:0] ERR_EXP_SEP     = 5'd15;
    localparam logic [4:0] ERR_TRAILING    = 5'd16;
    localparam logic [4:0] ERR_WS_OVERFLOW = 5'd17;

    localparam logic [4:0] PH_OPEN      = 5'd0;
    localparam logic [4:0] PH_FIRST     = 5'd1;
    localparam logic [4:0] PH_KEY_START = 5'd2;
    localparam logic [4:0] PH_KEY_STR   = 5'd3;
    localparam logic [4:0] PH_COLON     = 5'd10;
    localparam logic [4:0] PH_VALUE     = 5'd11;
    localparam logic [4:0] PH_VAL_STR   = 5'd12;
    localparam logic [4:0] PH_RAW       = 5'd19;
    localparam logic [4:0] PH_AFTER     = 5'd20;
    localparam logic [4:0] PH_TRAIL     = 5'd21;

    localparam logic [2:0] SUB_BODY   = 3'd0;
    localparam logic [2:0] SUB_ESC    = 3'd1;
    localparam logic [2:0] SUB_HEX    = 3'd2;
    localparam logic [2:0] SUB_BS     = 3'd3;
    localparam logic [2:0] SUB_U      = 3'd4;
    localparam logic [2:0] SUB_LOW    = 3'd5;
    localparam logic [2:0] SUB_LOWBAD = 3'd6;

    localparam logic [1:0] SRC_REG   = 2'd0;
    localparam logic [1:0] SRC_UTF8  = 2'd1;
    localparam logic [1:0] SRC_WS    = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [4:0] status_code;
        logic       last;
    } t_result;

    // Commands from the controller to the datapath for one cycle.
    typedef struct packed {
        logic       load_in;
        logic       ws_push;
        logic       ws_clear;
        logic       ws_rd_start;
        logic       ws_rd_next;
        logic       utf8_load;
        logic       utf8_next;
        logic       hex_clear;
        logic       hex_shift;
        logic       hi_load;
        logic       out_load;
        logic [1:0] out_src;
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic [4:0] out_status;
        logic       out_last;
        logic       cp_pair;
    } t_cmd;

    typedef struct packed {
        logic             out_busy;
        logic [7:0]       in_byte;
        logic             in_end;
        logic [15:0]      hex_accum;
        logic [2:0]       hex_count;
        logic [WS_CW-1:0] ws_count;
        logic             ws_rd_last;
        logic [2:0]       utf8_left;
    } t_stat;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
        return 5'd16;
    endfunction

endpackage

// File: src/fjot_stream_if.sv
interface fjot_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/fjot_datapath.sv
module fjot_datapath
    import fjot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_op,
    input  logic [7:0] i_in_byte,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic [7:0]       r_in_byte;
    logic             r_in_end;
    logic [15:0]      r_hex;
    logic [2:0]       r_hex_cnt;
    logic [9:0]       r_hi;
    logic [7:0]       r_ws_mem [WS_DEPTH];
    logic [WS_CW-1:0] r_ws_cnt;
    logic [WS_CW-1:0] r_rd_ptr;
    logic [7:0]       r_ws_q;
    logic [20:0]      r_cp;
    logic [2:0]       r_u_left;
    logic [2:0]       r_u_kind;
    logic             r_valid;
    t_result          r_res;
    logic [20:0]      n_cp;
    logic [2:0]       n_len;
    logic [7:0]       u_byte;
    logic [2:0]       u_idx;
    logic [4:0]       hex_nib;

    assign hex_nib = hex_val(r_in_byte);

    always_comb begin
        if (i_cmd.cp_pair) begin
            n_cp = 21'h10000 + {1'b0, r_hi, 10'd0} + {11'd0, 10'(r_hex - 16'hdc00)};
        end else begin
            n_cp = {5'd0, r_hex};
        end
        if (n_cp <= 21'h7f) n_len = 3'd1;
        else if (n_cp <= 21'h7ff) n_len = 3'd2;
        else if (n_cp <= 21'hffff) n_len = 3'd3;
        else n_len = 3'd4;
    end

    always_comb begin
        u_idx = r_u_left;
        u_byte = 8'h80 | {2'b00, r_cp[5:0]};
        unique case (r_u_kind)
            3'd1: u_byte = r_cp[7:0];
            3'd2: u_byte = (u_idx == 3'd2) ? (8'hc0 | {3'b0, r_cp[10:6]})
                                           : (8'h80 | {2'b0, r_cp[5:0]});
            3'd3: begin
                if (u_idx == 3'd3) u_byte = 8'he0 | {4'b0, r_cp[15:12]};
                else if (u_idx == 3'd2) u_byte = 8'h80 | {2'b0, r_cp[11:6]};
                else u_byte = 8'h80 | {2'b0, r_cp[5:0]};
            end
            default: begin
                if (u_idx == 3'd4) u_byte = 8'hf0 | {5'b0, r_cp[20:18]};
                else if (u_idx == 3'd3) u_byte = 8'h80 | {2'b0, r_cp[17:12]};
                else if (u_idx == 3'd2) u_byte = 8'h80 | {2'b0, r_cp[11:6]};
                else u_byte = 8'h80 | {2'b0, r_cp[5:0]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_byte <= i_in_byte;
            r_in_end <= i_in_op;
        end
        if (i_cmd.hex_clear) begin
            r_hex <= '0;
            r_hex_cnt <= '0;
        end else if (i_cmd.hex_shift) begin
            if (hex_nib <= 5'd15) begin
                r_hex <= {r_hex[11:0], hex_nib[3:0]};
            end
            if (r_hex_cnt < 3'd3) r_hex_cnt <= r_hex_cnt + 3'd1;
        end
        if (i_cmd.hi_load) r_hi <= 10'(r_hex - 16'hd800);
        if (i_cmd.ws_push && r_ws_cnt < WS_CW'(WS_DEPTH)) begin
            r_ws_mem[r_ws_cnt[WS_AW-1:0]] <= r_in_byte;
        end
        if (i_cmd.ws_rd_start) begin
            r_ws_q <= r_ws_mem[0];
        end else if (i_cmd.ws_rd_next) begin
            r_ws_q <= r_ws_mem[r_rd_ptr[WS_AW-1:0]];
        end
        if (i_cmd.utf8_load) begin
            r_cp <= n_cp;
            r_u_kind <= n_len;
        end
        if (i_cmd.out_load) begin
            r_res.kind <= i_cmd.out_kind;
            r_res.status_code <= i_cmd.out_status;
            r_res.last <= i_cmd.out_last;
            unique case (i_cmd.out_src)
                SRC_UTF8: r_res.out_byte <= u_byte;
                SRC_WS:   r_res.out_byte <= r_ws_q;
                default:  r_res.out_byte <= i_cmd.out_byte;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws_cnt <= '0;
            r_rd_ptr <= '0;
            r_u_left <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.ws_clear) begin
                r_ws_cnt <= '0;
            end else if (i_cmd.ws_push && r_ws_cnt < WS_CW'(WS_DEPTH)) begin
                r_ws_cnt <= r_ws_cnt + 1'b1;
            end
            if (i_cmd.ws_rd_start) begin
                r_rd_ptr <= WS_CW'(1);
            end else if (i_cmd.ws_rd_next) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_cmd.utf8_load) begin
                r_u_left <= n_len;
            end else if (i_cmd.utf8_next) begin
                r_u_left <= r_u_left - 3'd1;
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.out_busy = r_valid && !i_ready;
        o_stat.in_byte = r_in_byte;
        o_stat.in_end = r_in_end;
        o_stat.hex_accum = r_hex;
        o_stat.hex_count = r_hex_cnt;
        o_stat.ws_count = r_ws_cnt;
        o_stat.ws_rd_last = r_rd_ptr >= r_ws_cnt;
        o_stat.utf8_left = r_u_left;
    end

    assign o_valid = r_valid;
    assign o_res = r_res;

    a_ws_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws_cnt <= WS_CW'(WS_DEPTH)) else $error("whitespace count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_res))
        else $error("result changed while stalled");
    a_utf8_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u_left <= 3'd4) else $error("bad UTF-8 length");

endmodule

// File: src/fjot_ctrl.sv
module fjot_ctrl
    import fjot_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_UTF8  = 3'd2;
    localparam logic [2:0] ST_WS    = 3'd3;
    localparam logic [2:0] ST_WSTL  = 3'd4;

    logic [2:0] r_st, n_st;
    logic [4:0] r_phase, n_phase;
    logic [4:0] r_err, n_err;
    logic [2:0] r_ukind, n_ukind;
    logic [2:0] r_tailk, n_tailk;

    logic [7:0] c;
    logic       in_key;
    logic [4:0] base;
    logic [2:0] sub;
    logic [2:0] skind;
    logic [4:0] end_st;
    logic [4:0] nib;

    always_comb begin
        c = i_stat.in_byte;
        nib = hex_val(c);
        in_key = r_phase >= PH_KEY_STR && r_phase < PH_COLON;
        base = in_key ? PH_KEY_STR : PH_VAL_STR;
        sub = 3'(r_phase - base);
        skind = in_key ? KIND_KEY_BYTE : KIND_VAL_BYTE;
    end

    always_comb begin
        end_st = ERR_NONE;
        if (r_err != ERR_NONE) begin
            end_st = r_err;
        end else if ((r_phase >= PH_KEY_STR && r_phase < PH_COLON)
                || (r_phase >= PH_VAL_STR && r_phase < PH_RAW)) begin
            unique case (sub)
                SUB_BODY: end_st = ERR_UNT_STRING;
                SUB_ESC:  end_st = ERR_UNT_ESCAPE;
                SUB_HEX:  end_st = ERR_BAD_UNICODE;
                default:  end_st = ERR_HIGH_NO_U;
            endcase
        end else begin
            priority case (r_phase)
                PH_OPEN: end_st = ERR_EXP_OBJECT;
                PH_FIRST, PH_KEY_START: end_st = ERR_EXP_STRING;
                PH_COLON: end_st = ERR_EXP_COLON;
                PH_VALUE: end_st = ERR_NO_VALUE;
                PH_RAW, PH_AFTER: end_st = ERR_UNT_OBJECT;
                default: end_st = ERR_NONE;
            endcase
        end
    end

    task automatic emit(input logic [2:0] k, input logic [7:0] b, input logic [4:0] s,
                        input logic l);
        o_cmd.out_load = 1'b1;
        o_cmd.out_src = SRC_REG;
        o_cmd.out_kind = k;
        o_cmd.out_byte = b;
        o_cmd.out_status = s;
        o_cmd.out_last = l;
    endtask

    always_comb begin
        o_cmd = '0;
        n_st = r_st;
        n_phase = r_phase;
        n_err = r_err;
        n_ukind = r_ukind;
        n_tailk = r_tailk;
        o_in_ready = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_st = ST_EXEC;
            end
            ST_EXEC: begin
                if (!i_stat.out_busy) begin
                    n_st = ST_IDLE;
                    if (i_stat.in_end) begin
                        emit(KIND_STATUS, 8'd0, end_st, 1'b1);
                        n_phase = PH_OPEN;
                        n_err = ERR_NONE;
                        o_cmd.hex_clear = 1'b1;
                        o_cmd.ws_clear = 1'b1;
                    end else if (r_err == ERR_NONE) begin
                        priority case (1'b1)
                            r_phase == PH_OPEN: begin
                                if (c == "{") n_phase = PH_FIRST;
                                else if (!is_ws(c)) n_err = ERR_EXP_OBJECT;
                            end
                            r_phase == PH_FIRST || r_phase == PH_KEY_START: begin
                                if (c == "\"") n_phase = PH_KEY_STR;
                                else if (c == "}" && r_phase == PH_FIRST) n_phase = PH_TRAIL;
                                else if (!is_ws(c)) n_err = ERR_EXP_STRING;
                            end
                            r_phase == PH_COLON: begin
                                if (c == ":") n_phase = PH_VALUE;
                                else if (!is_ws(c)) n_err = ERR_EXP_COLON;
                            end
                            r_phase == PH_VALUE: begin
                                if (is_ws(c)) begin
                                end else if (c == "\"") n_phase = PH_VAL_STR;
                                else if (c == "{" || c == "[") n_err = ERR_NESTED;
                                else if (c == "," || c == "}") n_err = ERR_NO_SCALAR;
                                else begin
                                    n_phase = PH_RAW;
                                    o_cmd.ws_clear = 1'b1;
                                    emit(KIND_VAL_BYTE, c, ERR_NONE, 1'b1);
                                end
                            end
                            r_phase == PH_RAW: begin
                                if (is_ws(c)) begin
                                    if (i_stat.ws_count >= WS_CW'(WS_DEPTH)) begin
                                        n_err = ERR_WS_OVERFLOW;
                                    end else begin
                                        o_cmd.ws_push = 1'b1;
                                    end
                                end else if (c == "," || c == "}") begin
                                    o_cmd.ws_clear = 1'b1;
                                    emit(KIND_PAIR_END, 8'd0, ERR_NONE, 1'b1);
                                    n_phase = (c == ",") ? PH_KEY_START : PH_TRAIL;
                                end else if (i_stat.ws_count != '0) begin
                                    o_cmd.ws_rd_start = 1'b1;
                                    n_st = ST_WS;
                                end else begin
                                    emit(KIND_VAL_BYTE, c, ERR_NONE, 1'b1);
                                end
                            end
                            r_phase == PH_AFTER: begin
                                if (c == "," || c == "}") begin
                                    emit(KIND_PAIR_END, 8'd0, ERR_NONE, 1'b1);
                                    n_phase = (c == ",") ? PH_KEY_START : PH_TRAIL;
                                end else if (!is_ws(c)) n_err = ERR_EXP_SEP;
                            end
                            r_phase == PH_TRAIL: begin
                                if (!is_ws(c)) n_err = ERR_TRAILING;
                            end
                            in_key || (r_phase >= PH_VAL_STR && r_phase < PH_RAW): begin
                                unique case (sub)
                                    SUB_BODY: begin
                                        if (c == "\"") begin
                                            if (in_key) begin
                                                emit(KIND_KEY_END, 8'd0, ERR_NONE, 1'b1);
                                                n_phase = PH_COLON;
                                            end else n_phase = PH_AFTER;
                                        end else if (c == "\\") begin
                                            n_phase = base + 5'(SUB_ESC);
                                        end else begin
                                            emit(skind, c, ERR_NONE, 1'b1);
                                        end
                                    end
                                    SUB_ESC: begin
                                        n_phase = base + 5'(SUB_BODY);
                                        priority case (c)
                                            "\"", "\\", "/": emit(skind, c, ERR_NONE, 1'b1);
                                            "b": emit(skind, 8'h08, ERR_NONE, 1'b1);
                                            "f": emit(skind, 8'h0c, ERR_NONE, 1'b1);
                                            "n": emit(skind, 8'h0a, ERR_NONE, 1'b1);
                                            "r": emit(skind, 8'h0d, ERR_NONE, 1'b1);
                                            "t": emit(skind, 8'h09, ERR_NONE, 1'b1);
                                            "u": begin
                                                o_cmd.hex_clear = 1'b1;
                                                n_phase = base + 5'(SUB_HEX);
                                            end
                                            default: begin
                                                n_phase = r_phase;
                                                n_err = ERR_BAD_ESCAPE;
                                            end
                                        endcase
                                    end
                                    SUB_HEX: begin
                                        if (nib > 5'd15) begin
                                            n_err = ERR_BAD_UNICODE;
                                        end else begin
                                            o_cmd.hex_shift = 1'b1;
                                            if (i_stat.hex_count == 3'd3) n_st = ST_WSTL;
                                        end
                                    end
                                    SUB_BS: begin
                                        if (c == "\\") n_phase = base + 5'(SUB_U);
                                        else n_err = ERR_HIGH_NO_U;
                                    end
                                    SUB_U: begin
                                        if (c == "u") begin
                                            o_cmd.hex_clear = 1'b1;
                                            n_phase = base + 5'(SUB_LOW);
                                        end else n_err = ERR_HIGH_NO_U;
                                    end
                                    default: begin
                                        o_cmd.hex_shift = 1'b1;
                                        if (nib > 5'd15) n_phase = base + 5'(SUB_LOWBAD);
                                        if (i_stat.hex_count == 3'd3) n_st = ST_WSTL;
                                    end
                                endcase
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ST_WSTL: begin
                // Four hex digits are in; classify the code point.
                n_st = ST_IDLE;
                if (sub == SUB_HEX) begin
                    if (i_stat.hex_accum >= 16'hd800 && i_stat.hex_accum <= 16'hdbff) begin
                        o_cmd.hi_load = 1'b1;
                        n_phase = base + 5'(SUB_BS);
                    end else if (i_stat.hex_accum >= 16'hdc00
                            && i_stat.hex_accum <= 16'hdfff) begin
                        n_err = ERR_LONE_LOW;
                    end else begin
                        o_cmd.utf8_load = 1'b1;
                        n_ukind = skind;
                        n_phase = base + 5'(SUB_BODY);
                        n_st = ST_UTF8;
                    end
                end else if (sub == SUB_LOW && i_stat.hex_accum >= 16'hdc00
                        && i_stat.hex_accum <= 16'hdfff) begin
                    o_cmd.utf8_load = 1'b1;
                    o_cmd.cp_pair = 1'b1;
                    n_ukind = skind;
                    n_phase = base + 5'(SUB_BODY);
                    n_st = ST_UTF8;
                end else begin
                    n_err = ERR_BAD_LOW;
                end
            end
            ST_UTF8: begin
                if (!i_stat.out_busy) begin
                    emit(r_ukind, 8'd0, ERR_NONE, i_stat.utf8_left == 3'd1);
                    o_cmd.out_src = SRC_UTF8;
                    o_cmd.utf8_next = 1'b1;
                    if (i_stat.utf8_left == 3'd1) n_st = ST_IDLE;
                end
            end
            ST_WS: begin
                if (!i_stat.out_busy) begin
                    if (r_tailk == 3'd1) begin
                        emit(KIND_VAL_BYTE, c, ERR_NONE, 1'b1);
                        o_cmd.ws_clear = 1'b1;
                        n_tailk = 3'd0;
                        n_st = ST_IDLE;
                    end else begin
                        emit(KIND_VAL_BYTE, 8'd0, ERR_NONE, 1'b0);
                        o_cmd.out_src = SRC_WS;
                        o_cmd.ws_rd_next = 1'b1;
                        if (i_stat.ws_rd_last) n_tailk = 3'd1;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_phase <= PH_OPEN;
            r_err <= ERR_NONE;
            r_ukind <= KIND_KEY_BYTE;
            r_tailk <= 3'd0;
        end else begin
            r_st <= n_st;
            r_phase <= n_phase;
            r_err <= n_err;
            r_ukind <= n_ukind;
            r_tailk <= n_tailk;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_st == ST_IDLE) else $error("ready outside idle");
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err <= ERR_WS_OVERFLOW) else $error("bad error code");
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_err) != ERR_NONE && r_err != ERR_NONE |-> r_err == $past(r_err))
        else $error("latched error changed");

endmodule

// File: src/flat_json_object_tokenizer.sv
// Flat JSON object tokenizer.
// The input channel carries one transaction per text byte (operation 0) or an
// end-of-text marker (operation 1). The output channel carries result
// transactions: key bytes, value bytes, key end, pair end and the final status.
// The last result caused by an input has last set.
// An input is taken in the idle state and registered, then decoded in the
// execute state once the output register is free; a plain byte then loads
// its result into the output register. The next input is taken only back in
// idle, so inputs never overlap. A unicode escape passes a classify state for
// the code point, then a UTF-8 state emits its bytes. A byte that ends pending
// whitespace inside a bare value first replays the buffered whitespace bytes;
// the buffer holds WS_DEPTH bytes, and a longer run is reported as an error.
// The first error is latched and later bytes give no results; end of text
// returns the status and restarts the parser.
// Reset clears the parser state and drops any pending result.
// When the receiver holds ready low, the output register keeps its result; at
// most one more input is taken, and it waits until the result is gone.
module flat_json_object_tokenizer
    import fjot_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    fjot_stream_if.sink   in_if,
    fjot_stream_if.source out_if
);

    t_cmd  cmd;
    t_stat stat;
    t_result res;

    fjot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_if.valid),
        .o_in_ready (in_if.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fjot_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_op   (in_if.data.operation),
        .i_in_byte (in_if.data.data_byte),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_valid   (out_if.valid),
        .i_ready   (out_if.ready),
        .o_res     (res)
    );

    assign out_if.data.kind = res.kind;
    assign out_if.data.out_byte = res.out_byte;
    assign out_if.data.status_code = res.status_code;
    assign out_if.data.last = res.last;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fjot_pkg::*;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_item;

    typedef struct {
        logic       op;
        logic [7:0] b;
        bit         sync;
    } t_stim;

    localparam int LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;

    fjot_stream_if #(.T(t_item))   in_ch();
    fjot_stream_if #(.T(t_result)) out_ch();

    flat_json_object_tokenizer DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_if  (in_ch.sink),
        .out_if (out_ch.source)
    );

    t_stim      text_q[$];
    t_result    token_q[$];
    logic [7:0] txt[$];

    logic [4:0]  ph;
    logic [15:0] hx;
    logic [2:0]  hc;
    logic [9:0]  hs;
    logic [7:0]  ws_buf[WS_DEPTH];
    int          ws_cnt;
    logic [4:0]  err;

    int n_errors, n_sent, n_tokens, n_docs, n_cycles;
    int gap, stall, hold;
    bit in_idle, out_idle, hold_done;

    task automatic report(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    function automatic bit blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [4:0] nibble(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    function automatic void put(logic [2:0] k, logic [7:0] b, logic [4:0] st);
        t_result r;
        r = '{kind: k, out_byte: b, status_code: st, last: 1'b0};
        token_q.insert(token_q.size(), r);
    endfunction

    function automatic void put_utf8(logic [2:0] k, logic [20:0] cp);
        if (cp <= 21'h7f) begin
            put(k, cp[7:0], ERR_NONE);
        end else if (cp <= 21'h7ff) begin
            put(k, 8'hc0 | cp[10:6], ERR_NONE);
            put(k, 8'h80 | cp[5:0], ERR_NONE);
        end else if (cp <= 21'hffff) begin
            put(k, 8'he0 | cp[15:12], ERR_NONE);
            put(k, 8'h80 | cp[11:6], ERR_NONE);
            put(k, 8'h80 | cp[5:0], ERR_NONE);
        end else begin
            put(k, 8'hf0 | cp[20:18], ERR_NONE);
            put(k, 8'h80 | cp[17:12], ERR_NONE);
            put(k, 8'h80 | cp[11:6], ERR_NONE);
            put(k, 8'h80 | cp[5:0], ERR_NONE);
        end
    endfunction

    function automatic void string_step(logic [4:0] base, logic [7:0] c);
        int         sub;
        logic [2:0] k;
        logic [4:0] n;
        logic [7:0] d;
        logic [20:0] cp;
        sub = ph - base;
        k = (base == PH_KEY_STR) ? KIND_KEY_BYTE : KIND_VAL_BYTE;
        case (sub)
            SUB_BODY: begin
                if (c == "\"") begin
                    if (base == PH_KEY_STR) begin
                        put(KIND_KEY_END, 8'h00, ERR_NONE);
                        ph = PH_COLON;
                    end else begin
                        ph = PH_AFTER;
                    end
                end else if (c == "\\") begin
                    ph = base + SUB_ESC;
                end else begin
                    put(k, c, ERR_NONE);
                end
            end
            SUB_ESC: begin
                case (c)
                    "\"": d = 8'h22;
                    "\\": d = 8'h5c;
                    "/": d = 8'h2f;
                    "b": d = 8'h08;
                    "f": d = 8'h0c;
                    "n": d = 8'h0a;
                    "r": d = 8'h0d;
                    "t": d = 8'h09;
                    "u": begin
                        hx = 0;
                        hc = 0;
                        ph = base + SUB_HEX;
                        return;
                    end
                    default: begin
                        err = ERR_BAD_ESCAPE;
                        return;
                    end
                endcase
                put(k, d, ERR_NONE);
                ph = base + SUB_BODY;
            end
            SUB_HEX: begin
                n = nibble(c);
                if (n > 15) begin
                    err = ERR_BAD_UNICODE;
                    return;
                end
                hx = {hx[11:0], n[3:0]};
                if (hc < 3) begin
                    hc++;
                    return;
                end
                if (hx >= 16'hd800 && hx <= 16'hdbff) begin
                    hs = 10'(hx - 16'hd800);
                    ph = base + SUB_BS;
                end else if (hx >= 16'hdc00 && hx <= 16'hdfff) begin
                    err = ERR_LONE_LOW;
                end else begin
                    put_utf8(k, {5'd0, hx});
                    ph = base + SUB_BODY;
                end
            end
            SUB_BS: begin
                if (c == "\\") ph = base + SUB_U;
                else err = ERR_HIGH_NO_U;
            end
            SUB_U: begin
                if (c == "u") begin
                    hx = 0;
                    hc = 0;
                    ph = base + SUB_LOW;
                end else begin
                    err = ERR_HIGH_NO_U;
                end
            end
            default: begin
                n = nibble(c);
                if (n > 15) ph = base + SUB_LOWBAD;
                else hx = {hx[11:0], n[3:0]};
                if (hc < 3) begin
                    hc++;
                    return;
                end
                if (ph == base + SUB_LOW && hx >= 16'hdc00 && hx <= 16'hdfff) begin
                    cp = 21'h10000 + {1'b0, hs, 10'd0} + 21'(hx - 16'hdc00);
                    put_utf8(k, cp);
                    ph = base + SUB_BODY;
                end else begin
                    err = ERR_BAD_LOW;
                end
            end
        endcase
    endfunction

    function automatic logic [4:0] end_code();
        logic [4:0] p;
        if (err != ERR_NONE) return err;
        p = ph;
        if (p >= PH_KEY_STR && p < PH_COLON) p = p - PH_KEY_STR + PH_VAL_STR;
        case (p)
            PH_OPEN: return ERR_EXP_OBJECT;
            PH_FIRST, PH_KEY_START: return ERR_EXP_STRING;
            PH_COLON: return ERR_EXP_COLON;
            PH_VALUE: return ERR_NO_VALUE;
            PH_RAW, PH_AFTER: return ERR_UNT_OBJECT;
            PH_TRAIL: return ERR_NONE;
            PH_VAL_STR + SUB_BODY: return ERR_UNT_STRING;
            PH_VAL_STR + SUB_ESC: return ERR_UNT_ESCAPE;
            PH_VAL_STR + SUB_HEX: return ERR_BAD_UNICODE;
            PH_VAL_STR + SUB_BS, PH_VAL_STR + SUB_U,
            PH_VAL_STR + SUB_LOW, PH_VAL_STR + SUB_LOWBAD: return ERR_HIGH_NO_U;
            default: return ERR_NONE;
        endcase
    endfunction

    function automatic void parser_clear();
        ph = PH_OPEN;
        hx = 0;
        hc = 0;
        hs = 0;
        ws_cnt = 0;
        err = ERR_NONE;
    endfunction

    function automatic void tokenize(logic op, logic [7:0] c);
        int first;
        first = token_q.size();
        if (op) begin
            put(KIND_STATUS, 8'h00, end_code());
            parser_clear();
        end else if (err == ERR_NONE) begin
            case (ph)
                PH_OPEN: begin
                    if (c == "{") ph = PH_FIRST;
                    else if (!blank(c)) err = ERR_EXP_OBJECT;
                end
                PH_FIRST, PH_KEY_START: begin
                    if (c == "\"") ph = PH_KEY_STR;
                    else if (c == "}" && ph == PH_FIRST) ph = PH_TRAIL;
                    else if (!blank(c)) err = ERR_EXP_STRING;
                end
                PH_COLON: begin
                    if (c == ":") ph = PH_VALUE;
                    else if (!blank(c)) err = ERR_EXP_COLON;
                end
                PH_VALUE: begin
                    if (!blank(c)) begin
                        if (c == "\"") ph = PH_VAL_STR;
                        else if (c == "{" || c == "[") err = ERR_NESTED;
                        else if (c == "," || c == "}") err = ERR_NO_SCALAR;
                        else begin
                            ph = PH_RAW;
                            ws_cnt = 0;
                            put(KIND_VAL_BYTE, c, ERR_NONE);
                        end
                    end
                end
                PH_RAW: begin
                    if (blank(c)) begin
                        if (ws_cnt >= WS_DEPTH) err = ERR_WS_OVERFLOW;
                        else ws_buf[ws_cnt++] = c;
                    end else if (c == "," || c == "}") begin
                        ws_cnt = 0;
                        put(KIND_PAIR_END, 8'h00, ERR_NONE);
                        ph = (c == ",") ? PH_KEY_START : PH_TRAIL;
                    end else begin
                        for (int i = 0; i < ws_cnt; i++) put(KIND_VAL_BYTE, ws_buf[i], ERR_NONE);
                        ws_cnt = 0;
                        put(KIND_VAL_BYTE, c, ERR_NONE);
                    end
                end
                PH_AFTER: begin
                    if (c == "," || c == "}") begin
                        put(KIND_PAIR_END, 8'h00, ERR_NONE);
                        ph = (c == ",") ? PH_KEY_START : PH_TRAIL;
                    end else if (!blank(c)) begin
                        err = ERR_EXP_SEP;
                    end
                end
                PH_TRAIL: begin
                    if (!blank(c)) err = ERR_TRAILING;
                end
                default: begin
                    if (ph >= PH_KEY_STR && ph < PH_COLON) string_step(PH_KEY_STR, c);
                    else if (ph >= PH_VAL_STR && ph < PH_RAW) string_step(PH_VAL_STR, c);
                end
            endcase
        end
        if (token_q.size() > first) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    // Stimulus construction.
    function automatic void add_byte(logic [7:0] c);
        txt.insert(txt.size(), c);
    endfunction

    function automatic void add(string s);
        foreach (s[i]) add_byte(s[i]);
    endfunction

    function automatic void add_ws(int lo, int hi);
        byte unsigned blanks[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) add_byte(blanks[$urandom_range(5, 0)]);
    endfunction

    function automatic void add_hex(logic [15:0] v);
        string digits;
        int    d;
        digits = ($urandom_range(1, 0) == 1) ? "0123456789abcdef" : "0123456789ABCDEF";
        for (int i = 3; i >= 0; i--) begin
            d = (v >> (4 * i)) & 4'hf;
            add_byte(digits[d]);
        end
    endfunction

    function automatic void add_string();
        string esc = "\"\\/bfnrt";
        logic [7:0] c;
        logic [15:0] v;
        int n;
        n = $urandom_range(4, 0);
        add_byte("\"");
        repeat (n) begin
            case ($urandom_range(5, 0))
                0, 1: begin
                    c = 8'($urandom_range(8'h7e, 8'h20));
                    if (c == "\"" || c == "\\") c = "x";
                    add_byte(c);
                end
                2: add_byte(8'($urandom_range(8'hff, 8'h80)));
                3: begin
                    add_byte("\\");
                    add_byte(esc[$urandom_range(7, 0)]);
                end
                4: begin
                    v = 16'($urandom_range(16'hffff, 0));
                    if (v >= 16'hd800 && v <= 16'hdfff) v = v ^ 16'h8000;
                    add("\\u");
                    add_hex(v);
                end
                default: begin
                    add("\\u");
                    add_hex(16'(16'hd800 + $urandom_range(16'h3ff, 0)));
                    add("\\u");
                    add_hex(16'(16'hdc00 + $urandom_range(16'h3ff, 0)));
                end
            endcase
        end
        add_byte("\"");
    endfunction

    function automatic void add_scalar();
        string heads = "-0123456789tfnx.";
        string body = "0123456789abcdefEz.+-";
        int n;
        add_byte(heads[$urandom_range(15, 0)]);
        n = $urandom_range(4, 0);
        repeat (n) begin
            case ($urandom_range(5, 0))
                0: add_ws(1, 3);
                1: begin
                    if ($urandom_range(3, 0) == 0) add_ws(WS_DEPTH, WS_DEPTH + 1);
                    else add_ws(4, 8);
                end
                default: add_byte(body[$urandom_range(20, 0)]);
            endcase
        end
        add_ws(0, 3);
    endfunction

    function automatic void queue_text(bit sync);
        t_stim s;
        foreach (txt[i]) begin
            s = '{op: 1'b0, b: txt[i], sync: sync && i == 0};
            text_q.insert(text_q.size(), s);
        end
        s = '{op: 1'b1, b: 8'($urandom_range(255, 0)), sync: 1'b0};
        text_q.insert(text_q.size(), s);
        txt.delete();
        n_docs++;
    endfunction

    function automatic void random_object();
        int pairs, pos;
        add_ws(0, 2);
        add_byte("{");
        pairs = $urandom_range(3, 0);
        if (pairs == 0) add_ws(0, 2);
        for (int p = 0; p < pairs; p++) begin
            add_ws(0, 1);
            add_string();
            add_ws(0, 1);
            add_byte(":");
            add_ws(0, 1);
            if ($urandom_range(1, 0) == 1) add_string();
            else add_scalar();
            add_ws(0, 1);
            if (p < pairs - 1) add_byte(",");
        end
        add_byte("}");
        add_ws(0, 2);
        case ($urandom_range(9, 0))
            0, 1: begin
                pos = $urandom_range(txt.size() - 1, 0);
                txt[pos] = 8'($urandom_range(255, 0));
            end
            2: begin
                pos = $urandom_range(txt.size() - 1, 0);
                while (txt.size() > pos) void'(txt.pop_back());
            end
            3: begin
                repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(255, 0)));
            end
            default: ;
        endcase
        queue_text($urandom_range(7, 0) == 0);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        parser_clear();

        add("{\"k\\u07FF\":a b }");
        queue_text(1'b0);
        add("{}");
        queue_text(1'b0);
        add_byte(8'hff);
        queue_text(1'b0);
        add("{\"");
        add_byte(8'h00);
        queue_text(1'b0);
        while (text_q.size() < 360) random_object();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (text_q.size() != 0 || in_ch.valid);
        do @(posedge i_clk); while (token_q.size() != 0);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d input transactions in %0d documents.", n_sent, n_docs);
        $display("Checked %0d result transactions.", n_tokens);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("Timeout after %0d cycles.", n_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold <= 0;
            hold_done <= 1'b0;
        end else if (hold > 0) begin
            hold <= hold - 1;
        end else if (!hold_done && n_tokens >= 60) begin
            hold <= 400;
            hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stim s;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            gap = 0;
            in_idle = 1'b1;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                tokenize(in_ch.data.operation, in_ch.data.data_byte);
                n_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap > 0) begin
                    gap--;
                    in_ch.valid <= 1'b0;
                end else if (text_q.size() > 0 && (!text_q[0].sync || token_q.size() == 0)) begin
                    s = text_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data <= '{operation: s.op, data_byte: s.b};
                    if ($urandom_range(29, 0) == 0) in_idle = !in_idle;
                    gap = in_idle ? $urandom_range(15, 0) : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall = 0;
            out_idle = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                n_tokens++;
                if (token_q.size() == 0) begin
                    report($sformatf("unexpected result kind %0d byte %02h status %0d",
                                     got.kind, got.out_byte, got.status_code));
                end else begin
                    want = token_q.pop_front();
                    if (got.kind !== want.kind)
                        report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.out_byte !== want.out_byte)
                        report($sformatf("byte %02h, expected %02h", got.out_byte, want.out_byte));
                    if (got.status_code !== want.status_code)
                        report($sformatf("status %0d, expected %0d",
                                         got.status_code, want.status_code));
                    if (got.last !== want.last)
                        report($sformatf("last %0b, expected %0b", got.last, want.last));
                end
                if ($urandom_range(29, 0) == 0) out_idle = !out_idle;
                stall = out_idle ? $urandom_range(15, 0) : 0;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

endmodule
